// ===== sv/nfv5_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package nfv5_pkg;

	localparam logic [15:0] NF_VERSION = 16'd5;
	localparam int unsigned HDR_WORDS = 6;
	localparam int unsigned REC_WORDS = 12;

	// x / 1000 == (x * DIV1000_MUL) >> DIV1000_SHIFT, exact for every 32-bit x
	localparam int unsigned DIV1000_MUL_W = 29;
	localparam logic [DIV1000_MUL_W-1:0] DIV1000_MUL = 29'd274877907;
	localparam int unsigned DIV1000_SHIFT = 38;
	localparam int unsigned MS_Q_W = 23;

	localparam logic [31:0] K1000 = 32'd1000;

	typedef struct packed {
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [31:0] packet_count;
		logic [31:0] byte_count;
		logic [31:0] ms_first;
		logic [31:0] ms_last;
		logic [31:0] epoch_secs;
		logic [31:0] epoch_nsecs;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [7:0]  tcp_flag_bits;
		logic [7:0]  protocol;
		logic        end_of_batch;
	} flow_ms_t;

endpackage

`default_nettype wire

// ===== sv/nfv5_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface nfv5_flow_if;
	logic        valid;
	logic        ready;
	logic [31:0] src_ip;
	logic [31:0] dst_ip;
	logic [31:0] packet_count;
	logic [31:0] byte_count;
	logic [63:0] first_seen;
	logic [63:0] last_seen;
	logic [15:0] src_port;
	logic [15:0] dst_port;
	logic [7:0]  tcp_flag_bits;
	logic [7:0]  protocol;
	logic        end_of_batch;

	modport source (
		output valid, src_ip, dst_ip, packet_count, byte_count, first_seen, last_seen,
		output src_port, dst_port, tcp_flag_bits, protocol, end_of_batch,
		input  ready
	);
	modport sink (
		input  valid, src_ip, dst_ip, packet_count, byte_count, first_seen, last_seen,
		input  src_port, dst_port, tcp_flag_bits, protocol, end_of_batch,
		output ready
	);
endinterface

interface nfv5_word_if;
	logic        valid;
	logic        ready;
	logic [8:0]  word_index;
	logic [31:0] data_word;
	logic        last_of_packet;

	modport source (output valid, word_index, data_word, last_of_packet, input ready);
	modport sink (input valid, word_index, data_word, last_of_packet, output ready);
endinterface

`default_nettype wire

// ===== sv/nfv5_time.sv =====
`timescale 1ns / 1ps
`default_nettype none

module nfv5_time (
	input  logic              clk,
	input  logic              arst_n,
	nfv5_flow_if.sink         flow,
	output logic              out_valid,
	input  logic              out_ready,
	output nfv5_pkg::flow_ms_t out_rec
);
	import nfv5_pkg::*;

	localparam int unsigned ProdW = 32 + DIV1000_MUL_W;

	typedef struct packed {
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [31:0] packet_count;
		logic [31:0] byte_count;
		logic [63:0] first_seen;
		logic [63:0] last_seen;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [7:0]  tcp_flag_bits;
		logic [7:0]  protocol;
		logic        end_of_batch;
	} raw_t;

	raw_t              raw_s1;
	flow_ms_t          rec_s2, rec_s3, rec_c2, rec_c3;
	logic [MS_Q_W-1:0] qf_s2, ql_s2;
	logic              v_s1, v_s2, v_s3;
	logic              adv_s1, adv_s2, adv_s3;
	logic [ProdW-1:0]  prod_f, prod_l;

	assign adv_s3 = !v_s3 || out_ready;
	assign adv_s2 = !v_s2 || adv_s3;
	assign adv_s1 = !v_s1 || adv_s2;
	assign flow.ready = adv_s1;

	// stage 2: usec/1000 by reciprocal, secs*1000, usec*1000 for the header nsecs
	assign prod_f = ProdW'(raw_s1.first_seen[31:0]) * ProdW'(DIV1000_MUL);
	assign prod_l = ProdW'(raw_s1.last_seen[31:0]) * ProdW'(DIV1000_MUL);

	always_comb begin
		rec_c2               = '0;
		rec_c2.src_ip        = raw_s1.src_ip;
		rec_c2.dst_ip        = raw_s1.dst_ip;
		rec_c2.packet_count  = raw_s1.packet_count;
		rec_c2.byte_count    = raw_s1.byte_count;
		rec_c2.ms_first      = raw_s1.first_seen[63:32] * K1000;
		rec_c2.ms_last       = raw_s1.last_seen[63:32] * K1000;
		rec_c2.epoch_secs    = raw_s1.last_seen[63:32];
		rec_c2.epoch_nsecs   = raw_s1.last_seen[31:0] * K1000;
		rec_c2.src_port      = raw_s1.src_port;
		rec_c2.dst_port      = raw_s1.dst_port;
		rec_c2.tcp_flag_bits = raw_s1.tcp_flag_bits;
		rec_c2.protocol      = raw_s1.protocol;
		rec_c2.end_of_batch  = raw_s1.end_of_batch;
	end

	always_comb begin
		rec_c3          = rec_s2;
		rec_c3.ms_first = rec_s2.ms_first + 32'(qf_s2);
		rec_c3.ms_last  = rec_s2.ms_last + 32'(ql_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= flow.valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && flow.valid) begin
			raw_s1.src_ip        <= flow.src_ip;
			raw_s1.dst_ip        <= flow.dst_ip;
			raw_s1.packet_count  <= flow.packet_count;
			raw_s1.byte_count    <= flow.byte_count;
			raw_s1.first_seen    <= flow.first_seen;
			raw_s1.last_seen     <= flow.last_seen;
			raw_s1.src_port      <= flow.src_port;
			raw_s1.dst_port      <= flow.dst_port;
			raw_s1.tcp_flag_bits <= flow.tcp_flag_bits;
			raw_s1.protocol      <= flow.protocol;
			raw_s1.end_of_batch  <= flow.end_of_batch;
		end
		if (adv_s2 && v_s1) begin
			rec_s2 <= rec_c2;
			qf_s2  <= prod_f[DIV1000_SHIFT +: MS_Q_W];
			ql_s2  <= prod_l[DIV1000_SHIFT +: MS_Q_W];
		end
		if (adv_s3 && v_s2) begin
			rec_s3 <= rec_c3;
		end
	end

	assign out_valid = v_s3;
	assign out_rec   = rec_s3;

endmodule

`default_nettype wire

// ===== sv/nfv5_fmt.sv =====
`timescale 1ns / 1ps
`default_nettype none

module nfv5_fmt #(
	parameter int unsigned RECORDS_PER_PACKET = 30
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  nfv5_pkg::flow_ms_t in_rec,
	nfv5_word_if.source        words
);
	import nfv5_pkg::*;

	localparam int unsigned AllWords = REC_WORDS + HDR_WORDS;

	// exporter state
	logic [31:0] base_q, seq_q, hdr_up_q, hdr_secs_q, hdr_ns_q;
	logic [4:0]  rec_q;

	// flow being sent
	logic        busy_q, close_q;
	logic [4:0]  wcnt_q, cnt_q;
	logic [8:0]  base_idx_q;
	logic [31:0] rec_w_q [REC_WORDS];

	// output register
	logic        ov_q, olast_q;
	logic [8:0]  oidx_q;
	logic [31:0] odata_q;

	logic        emit, done, load, is_hdr, close_next;
	logic [4:0]  last_cnt, cnt_next, hofs;
	logic [2:0]  hsel;
	logic [31:0] base_eff, uptime, first_rel, first_ms;
	logic [8:0]  base_idx;
	logic [31:0] hdr_w [HDR_WORDS];
	logic [31:0] word;
	logic [8:0]  widx;
	logic        wlast;

	assign last_cnt = close_q ? 5'(AllWords - 1) : 5'(REC_WORDS - 1);
	assign emit     = busy_q && (!ov_q || words.ready);
	assign done     = emit && (wcnt_q == last_cnt);
	assign in_ready = !busy_q || done;
	assign load     = in_valid && in_ready;

	// uptime base latches from the first-seen time while it is still zero
	assign base_eff   = (base_q == '0) ? in_rec.ms_first : base_q;
	assign uptime     = in_rec.ms_last - base_eff;
	assign first_rel  = in_rec.ms_first - base_eff;
	assign first_ms   = (first_rel > uptime) ? uptime : first_rel;
	assign cnt_next   = rec_q + 5'd1;
	assign close_next = (cnt_next >= 5'(RECORDS_PER_PACKET)) || in_rec.end_of_batch;
	assign base_idx   = 9'(HDR_WORDS) + {1'b0, rec_q, 3'b000} + {2'b00, rec_q, 2'b00};

	assign hdr_w[0] = {NF_VERSION, 11'd0, cnt_q};
	assign hdr_w[1] = hdr_up_q;
	assign hdr_w[2] = hdr_secs_q;
	assign hdr_w[3] = hdr_ns_q;
	assign hdr_w[4] = seq_q;
	assign hdr_w[5] = '0;

	assign is_hdr = wcnt_q >= 5'(REC_WORDS);
	assign hofs   = wcnt_q - 5'(REC_WORDS);
	assign hsel   = hofs[2:0];

	always_comb begin
		if (is_hdr) begin
			word  = hdr_w[hsel];
			widx  = 9'(hsel);
			wlast = (hsel == 3'(HDR_WORDS - 1));
		end else begin
			word  = rec_w_q[wcnt_q[3:0]];
			widx  = base_idx_q + 9'(wcnt_q);
			wlast = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			wcnt_q     <= '0;
			ov_q       <= 1'b0;
			base_q     <= '0;
			seq_q      <= '0;
			rec_q      <= '0;
			hdr_up_q   <= '0;
			hdr_secs_q <= '0;
			hdr_ns_q   <= '0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				wcnt_q <= '0;
				base_q <= base_eff;
				rec_q  <= close_next ? 5'd0 : cnt_next;
				if (rec_q == '0) begin
					hdr_up_q   <= uptime;
					hdr_secs_q <= in_rec.epoch_secs;
					hdr_ns_q   <= in_rec.epoch_nsecs;
				end
			end else if (done) begin
				busy_q <= 1'b0;
			end else if (emit) begin
				wcnt_q <= wcnt_q + 5'd1;
			end

			if (done && close_q) seq_q <= seq_q + 32'(cnt_q);

			if (emit) ov_q <= 1'b1;
			else if (words.ready) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			close_q     <= close_next;
			cnt_q       <= cnt_next;
			base_idx_q  <= base_idx;
			rec_w_q[0]  <= in_rec.src_ip;
			rec_w_q[1]  <= in_rec.dst_ip;
			rec_w_q[2]  <= '0;
			rec_w_q[3]  <= '0;
			rec_w_q[4]  <= in_rec.packet_count;
			rec_w_q[5]  <= in_rec.byte_count;
			rec_w_q[6]  <= first_ms;
			rec_w_q[7]  <= uptime;
			rec_w_q[8]  <= {in_rec.src_port, in_rec.dst_port};
			rec_w_q[9]  <= {8'd0, in_rec.tcp_flag_bits, in_rec.protocol, 8'd0};
			rec_w_q[10] <= '0;
			rec_w_q[11] <= '0;
		end
		if (emit) begin
			oidx_q  <= widx;
			odata_q <= word;
			olast_q <= wlast;
		end
	end

	assign words.valid          = ov_q;
	assign words.word_index     = oidx_q;
	assign words.data_word      = odata_q;
	assign words.last_of_packet = olast_q;

endmodule

`default_nettype wire

// ===== sv/netflow_v5_packet_builder_core.sv =====
// NetFlow v5 export packet builder.
// Channel flow (sink): one flow record per beat. Channel words (source): one 32-bit
// big-endian packet word per beat, with its word position and a last-of-packet flag.
// Each flow gives twelve record words at positions 6+12*n, n being its slot in the
// open packet. When the packet reaches RECORDS_PER_PACKET records, or the flow has
// end_of_batch set, the six header words (positions 0..5) follow, the last one flagged.
// The first record word of a flow reaches the words port after the flow beat has passed
// the input register, the two timestamp conversion stages, the load into the formatter
// and the output register.
// Throughput: the output register sends one word per cycle while the receiver keeps ready
// high, so a flow is sent as 12 words, or 18 when it closes a packet. Up to three flows
// wait in the input register and conversion stages while one is being sent, and the next
// flow loads in the cycle the last word of the one before enters the output register.
// Reset clears the uptime base, sequence number, record count and header fields, and
// empties every stage. When the receiver holds ready low the output word is held, the
// stages fill, and flow.ready drops once they are full.
`timescale 1ns / 1ps
`default_nettype none

module netflow_v5_packet_builder_core #(
	parameter int unsigned RECORDS_PER_PACKET = 30
) (
	input  logic        clk,
	input  logic        arst_n,
	nfv5_flow_if.sink   flow,
	nfv5_word_if.source words
);
	import nfv5_pkg::*;

	logic     cv_valid, cv_ready;
	flow_ms_t cv_rec;

	nfv5_time u_time (
		.clk       (clk),
		.arst_n    (arst_n),
		.flow      (flow),
		.out_valid (cv_valid),
		.out_ready (cv_ready),
		.out_rec   (cv_rec)
	);

	nfv5_fmt #(
		.RECORDS_PER_PACKET (RECORDS_PER_PACKET)
	) u_fmt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cv_valid),
		.in_ready (cv_ready),
		.in_rec   (cv_rec),
		.words    (words)
	);

endmodule

`default_nettype wire

// ===== sv/nfv5_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module nfv5_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        valid,
	input logic        ready,
	input logic [8:0]  word_index,
	input logic [31:0] data_word,
	input logic        last_of_packet
);

	// a stalled beat stays up
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid)
		else $error("word beat dropped while stalled");

	// a stalled beat keeps its payload
	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> $stable(word_index) && $stable(data_word)
			&& $stable(last_of_packet))
		else $error("word payload changed while stalled");

	// position 5 is the closing header word and nothing else is flagged
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (last_of_packet == (word_index == 9'd5)))
		else $error("last_of_packet does not match word position 5");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> word_index <= 9'd365)
		else $error("word position beyond a full packet");

endmodule

bind netflow_v5_packet_builder_core nfv5_checker u_nfv5_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.valid          (words.valid),
	.ready          (words.ready),
	.word_index     (words.word_index),
	.data_word      (words.data_word),
	.last_of_packet (words.last_of_packet)
);

`default_nettype wire

// ===== tb/tb_netflow_v5_packet_builder_core.sv =====
`timescale 1ns / 1ps

typedef struct packed {
	logic [31:0] src_ip;
	logic [31:0] dst_ip;
	logic [31:0] packet_count;
	logic [31:0] byte_count;
	logic [63:0] first_seen;
	logic [63:0] last_seen;
	logic [15:0] src_port;
	logic [15:0] dst_port;
	logic [7:0]  tcp_flag_bits;
	logic [7:0]  protocol;
	logic        end_of_batch;
} flow_rec_t;

typedef struct packed {
	logic [8:0]  word_index;
	logic [31:0] data_word;
	logic        last_of_packet;
} export_word_t;

class export_packet_sb;
	int unsigned records_per_packet;
	logic [31:0] up_base;
	logic [31:0] seq_no;
	logic [4:0]  slot;
	logic [31:0] hdr_up;
	logic [31:0] hdr_secs;
	logic [31:0] hdr_nsecs;
	export_word_t words_due[$];
	int errors;

	function new(int unsigned rpp);
		records_per_packet = rpp;
		up_base = '0;
		seq_no = '0;
		slot = '0;
		hdr_up = '0;
		hdr_secs = '0;
		hdr_nsecs = '0;
		errors = 0;
	endfunction

	// seconds*1000 + usec/1000, wrapping at 32 bits
	function logic [31:0] millis(logic [63:0] t);
		logic [31:0] secs;
		logic [31:0] usec;
		secs = t[63:32];
		usec = t[31:0];
		return secs * 32'd1000 + usec / 32'd1000;
	endfunction

	function void push_word(int unsigned idx, logic [31:0] data, logic last);
		export_word_t w;
		w.word_index = idx[8:0];
		w.data_word = data;
		w.last_of_packet = last;
		words_due.push_back(w);
	endfunction

	function void note_flow(flow_rec_t f);
		logic [31:0] uptime;
		logic [31:0] first_ms;
		logic [31:0] rec [nfv5_pkg::REC_WORDS];
		logic [4:0]  cnt;
		int unsigned base_idx;
		if (up_base == '0)
			up_base = millis(f.first_seen);
		uptime = millis(f.last_seen) - up_base;
		first_ms = millis(f.first_seen) - up_base;
		if (first_ms > uptime)
			first_ms = uptime;
		if (slot == '0) begin
			hdr_up = uptime;
			hdr_secs = f.last_seen[63:32];
			hdr_nsecs = f.last_seen[31:0] * 32'd1000;
		end
		rec[0] = f.src_ip;
		rec[1] = f.dst_ip;
		rec[2] = '0;
		rec[3] = '0;
		rec[4] = f.packet_count;
		rec[5] = f.byte_count;
		rec[6] = first_ms;
		rec[7] = uptime;
		rec[8] = {f.src_port, f.dst_port};
		rec[9] = {8'h00, f.tcp_flag_bits, f.protocol, 8'h00};
		rec[10] = '0;
		rec[11] = '0;
		base_idx = nfv5_pkg::HDR_WORDS + nfv5_pkg::REC_WORDS * slot;
		for (int i = 0; i < nfv5_pkg::REC_WORDS; i++)
			push_word(base_idx + i, rec[i], 1'b0);
		slot = slot + 5'd1;
		if (slot >= records_per_packet || f.end_of_batch) begin
			cnt = slot;
			push_word(0, {nfv5_pkg::NF_VERSION, 11'd0, cnt}, 1'b0);
			push_word(1, hdr_up, 1'b0);
			push_word(2, hdr_secs, 1'b0);
			push_word(3, hdr_nsecs, 1'b0);
			push_word(4, seq_no, 1'b0);
			push_word(5, 32'd0, 1'b1);
			seq_no = seq_no + cnt;
			slot = '0;
		end
	endfunction

	function void check_word(logic [8:0] idx, logic [31:0] data, logic last);
		export_word_t w;
		if (words_due.size() == 0) begin
			errors++;
			if (errors <= 30)
				$display("%0t: unexpected word idx=%0d data=%h last=%b",
					$time, idx, data, last);
			return;
		end
		w = words_due.pop_front();
		if (idx !== w.word_index) begin
			errors++;
			if (errors <= 30)
				$display("%0t: word_index exp %0d got %0d", $time, w.word_index, idx);
		end
		if (data !== w.data_word) begin
			errors++;
			if (errors <= 30)
				$display("%0t: data_word (idx %0d) exp %h got %h",
					$time, w.word_index, w.data_word, data);
		end
		if (last !== w.last_of_packet) begin
			errors++;
			if (errors <= 30)
				$display("%0t: last_of_packet (idx %0d) exp %b got %b",
					$time, w.word_index, w.last_of_packet, last);
		end
	endfunction

	function int pending();
		return words_due.size();
	endfunction
endclass

module tb_netflow_v5_packet_builder_core;

	localparam int unsigned RPP = 30;

	logic clk;
	logic arst_n;
	int unsigned gap_pct;
	int unsigned stall_pct;
	logic [31:0] anchor_secs;

	nfv5_flow_if flow_ch ();
	nfv5_word_if word_ch ();

	export_packet_sb sb = new(RPP);

	netflow_v5_packet_builder_core #(
		.RECORDS_PER_PACKET(RPP)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.flow(flow_ch),
		.words(word_ch)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// output side: check the beat taken at this edge, then pick next ready
	initial word_ch.ready = 1'b0;
	always @(posedge clk) begin
		if (arst_n && word_ch.valid && word_ch.ready)
			sb.check_word(word_ch.word_index, word_ch.data_word, word_ch.last_of_packet);
		word_ch.ready <= arst_n && ($urandom_range(99) >= stall_pct);
	end

	task automatic send_flow(flow_rec_t f);
		while ($urandom_range(99) < gap_pct) begin
			flow_ch.valid <= 1'b0;
			@(posedge clk);
		end
		flow_ch.valid <= 1'b1;
		flow_ch.src_ip <= f.src_ip;
		flow_ch.dst_ip <= f.dst_ip;
		flow_ch.packet_count <= f.packet_count;
		flow_ch.byte_count <= f.byte_count;
		flow_ch.first_seen <= f.first_seen;
		flow_ch.last_seen <= f.last_seen;
		flow_ch.src_port <= f.src_port;
		flow_ch.dst_port <= f.dst_port;
		flow_ch.tcp_flag_bits <= f.tcp_flag_bits;
		flow_ch.protocol <= f.protocol;
		flow_ch.end_of_batch <= f.end_of_batch;
		do
			@(posedge clk);
		while (!flow_ch.ready);
		sb.note_flow(f);
	endtask

	task automatic wait_drain();
		flow_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	function automatic flow_rec_t rand_flow();
		flow_rec_t f;
		int unsigned kind;
		logic [31:0] secs;
		f.src_ip = $urandom;
		f.dst_ip = $urandom;
		f.packet_count = $urandom;
		f.byte_count = $urandom;
		f.src_port = 16'($urandom);
		f.dst_port = 16'($urandom);
		f.tcp_flag_bits = 8'($urandom);
		f.protocol = 8'($urandom);
		f.end_of_batch = 1'b0;
		kind = $urandom_range(99);
		secs = anchor_secs + $urandom_range(0, 50);
		if (kind < 60) begin
			f.first_seen = {secs, 32'($urandom_range(0, 999999))};
			f.last_seen = {secs + 32'($urandom_range(0, 30)), 32'($urandom_range(0, 999999))};
		end else if (kind < 75) begin
			// last before first: first time gets clamped
			f.last_seen = {secs, 32'($urandom_range(0, 999999))};
			f.first_seen = {secs + 32'($urandom_range(0, 30)), 32'($urandom_range(0, 999999))};
		end else begin
			f.first_seen = {$urandom, $urandom};
			f.last_seen = {$urandom, $urandom};
		end
		return f;
	endfunction

	// packets of random length closed by end_of_batch, or by count at the full size;
	// a few stray end_of_batch flags cut packets short
	task automatic run_packets(int unsigned n_items);
		int unsigned sent;
		int unsigned len;
		flow_rec_t f;
		sent = 0;
		len = RPP;
		while (sent < n_items) begin
			for (int unsigned i = 0; i < len; i++) begin
				f = rand_flow();
				if (i == len - 1)
					f.end_of_batch = (len == RPP) ? 1'($urandom_range(1)) : 1'b1;
				else
					f.end_of_batch = ($urandom_range(99) < 4);
				send_flow(f);
				sent++;
			end
			len = ($urandom_range(99) < 20) ? RPP : $urandom_range(1, RPP - 1);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		gap_pct = 0;
		stall_pct = 0;
		anchor_secs = $urandom_range(1, 2000000000);
		flow_ch.valid = 1'b0;
		flow_ch.src_ip = '0;
		flow_ch.dst_ip = '0;
		flow_ch.packet_count = '0;
		flow_ch.byte_count = '0;
		flow_ch.first_seen = '0;
		flow_ch.last_seen = '0;
		flow_ch.src_port = '0;
		flow_ch.dst_port = '0;
		flow_ch.tcp_flag_bits = '0;
		flow_ch.protocol = '0;
		flow_ch.end_of_batch = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero times: uptime base loads zero and stays open for reload
		send_flow('{32'd0, 32'd0, 32'd0, 32'd0, 64'd0, 64'd0, 16'd0, 16'd0, 8'd0, 8'd0, 1'b0});
		// base reloads from this first time
		send_flow('{32'h0a000001, 32'hc0a80101, 32'd17, 32'd1500,
			{32'd100, 32'd5000}, {32'd200, 32'd999999},
			16'd1234, 16'd80, 8'h1b, 8'd6, 1'b0});
		// first after last
		send_flow('{32'h01020304, 32'h05060708, 32'd1, 32'd64,
			{32'd300, 32'd0}, {32'd250, 32'd0},
			16'd53, 16'd53, 8'h00, 8'd17, 1'b0});
		// microseconds far beyond one second, nanosecond product wraps
		send_flow('{32'h7f000001, 32'h7f000002, 32'd2, 32'd128,
			{32'd400, 32'd5000000}, {32'd400, 32'hffffffff},
			16'd443, 16'd50000, 8'h12, 8'd6, 1'b1});
		// all ones, one-record packet
		send_flow('{32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
			64'hffffffffffffffff, 64'hffffffffffffffff,
			16'hffff, 16'hffff, 8'hff, 8'hff, 1'b1});
		// last time before the base: uptime wraps
		send_flow('{32'haaaaaaaa, 32'haaaaaaaa, 32'haaaaaaaa, 32'haaaaaaaa,
			64'd0, 64'd0, 16'haaaa, 16'haaaa, 8'haa, 8'haa, 1'b0});
		send_flow('{32'h55555555, 32'h55555555, 32'h55555555, 32'h55555555,
			64'h5555555555555555, 64'h5555555555555555,
			16'h5555, 16'h5555, 8'h55, 8'h55, 1'b1});
		wait_drain();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin gap_pct = 0; stall_pct = 0; end
				1: begin gap_pct = 45; stall_pct = 0; end
				2: begin gap_pct = 0; stall_pct = 45; end
				default: begin gap_pct = 10; stall_pct = 10; end
			endcase
			run_packets(125);
			wait_drain();
		end

		stall_pct = 0;
		wait_drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
